FILE: rtl/core/bc7_two_subset_block_packer_core_macros.svh
// ----------------------------------------------------------------------------
// BC7 block packer assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BC7_TWO_SUBSET_BLOCK_PACKER_CORE_MACROS_SVH
`define BC7_TWO_SUBSET_BLOCK_PACKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BC7P_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bc7p assertion failed");
// antecedent implies consequent in the next cycle
`define BC7P_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bc7p assertion failed");
`else
`define BC7P_ASSERT_IMP(label, clk, rst, ante, cons)
`define BC7P_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/bc7p_pkg.sv
// ----------------------------------------------------------------------------
// BC7 block packer package
// Request/result payload types, codes and constant tables.
// ----------------------------------------------------------------------------
package bc7p_pkg;

  typedef enum logic [1:0] {
    MODE_HEADER   = 2'd0,
    MODE_ENDPOINT = 2'd1,
    MODE_PIXEL    = 2'd2,
    MODE_NONE     = 2'd3
  } item_mode_t;

  typedef enum logic [1:0] {
    FMT_MODE1 = 2'd0,
    FMT_MODE3 = 2'd1,
    FMT_MODE7 = 2'd2,
    FMT_ALT7  = 2'd3
  } block_fmt_t;

  localparam int unsigned BLOCK_PIXELS = 16;
  localparam logic [2:0]  REG_FORMAT_ADDR = 3'd0;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] slot;
    logic [5:0] partition;
    logic [7:0] val_a;
    logic [7:0] val_b;
    logic [7:0] val_c;
    logic [7:0] val_d;
  } req_t;

  typedef struct packed {
    logic [63:0] block_word;
    logic        upper_half;
    logic        last;
  } res_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

  localparam logic [15:0] SHAPE_MASK [64] = '{
    16'hCCCC, 16'h8888, 16'hEEEE, 16'hECC8, 16'hC880, 16'hFEEC, 16'hFEC8, 16'hEC80,
    16'hC800, 16'hFFEC, 16'hFE80, 16'hE800, 16'hFFE8, 16'hFF00, 16'hFFF0, 16'hF000,
    16'hF710, 16'h008E, 16'h7100, 16'h08CE, 16'h008C, 16'h7310, 16'h3100, 16'h8CCE,
    16'h088C, 16'h3110, 16'h6666, 16'h366C, 16'h17E8, 16'h0FF0, 16'h718E, 16'h399C,
    16'hAAAA, 16'hF0F0, 16'h5A5A, 16'h33CC, 16'h3C3C, 16'h55AA, 16'h9696, 16'hA55A,
    16'h73CE, 16'h13C8, 16'h324C, 16'h3BDC, 16'h6996, 16'hC33C, 16'h9966, 16'h0660,
    16'h0272, 16'h04E4, 16'h4E40, 16'h2720, 16'hC936, 16'h936C, 16'h39C6, 16'h639C,
    16'h9336, 16'h9CC6, 16'h817E, 16'hE718, 16'hCCF0, 16'h0FCC, 16'h7744, 16'hEE22
  };

  localparam logic [3:0] SECOND_ANCHOR [64] = '{
    4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
    4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
    4'd15, 4'd2,  4'd8,  4'd2,  4'd2,  4'd8,  4'd8,  4'd15,
    4'd2,  4'd8,  4'd2,  4'd2,  4'd8,  4'd8,  4'd2,  4'd2,
    4'd15, 4'd15, 4'd6,  4'd8,  4'd2,  4'd8,  4'd15, 4'd15,
    4'd2,  4'd8,  4'd2,  4'd2,  4'd2,  4'd15, 4'd15, 4'd6,
    4'd6,  4'd2,  4'd6,  4'd8,  4'd15, 4'd15, 4'd2,  4'd2,
    4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd2,  4'd2,  4'd15
  };

  localparam logic [2:0] IDX2 [16] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
  };

  localparam logic [2:0] IDX3 [16] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3,
    3'd4, 3'd5, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
  };

endpackage

FILE: rtl/core/bc7_two_subset_block_packer_core.sv
// ----------------------------------------------------------------------------
// BC7 two-subset block packer
// Loads header, endpoint and pixel requests, packs a 128-bit BC7 block.
// ----------------------------------------------------------------------------
// A block is loaded as one header request, endpoint requests (channels 0..3)
// and sixteen pixel requests. The pixel request for position 15 starts the
// pack, during which req_stall is high: three states of anchor reads from
// the luma RAM, two passes of the serial scale divider (one per subset), an
// index pass over the luma RAM (one pixel read per cycle, three-stage
// pipeline) and a final step to hand the block to the result buffer. That
// last step stretches while the previous block's results are still waiting
// in the buffer. The block then leaves as two 64-bit results, lower half
// first, the second flagged last; loading of the next block overlaps with
// delivery of these results.
// ----------------------------------------------------------------------------
`include "bc7_two_subset_block_packer_core_macros.svh"

module bc7_two_subset_block_packer_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bc7p_pkg::req_t req_data,
  output logic           res_valid,
  input  logic           res_stall,
  output bc7p_pkg::res_t res_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ANC0 = 7'b0000010,
    S_ANC1 = 7'b0000100,
    S_ANC2 = 7'b0001000,
    S_DIV0 = 7'b0010000,
    S_DIV1 = 7'b0100000,
    S_PIX  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   done_pend; // packed block waiting for the result buffer

  // configuration
  logic [1:0] block_format;
  logic       fmt0;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == bc7p_pkg::REG_FORMAT_ADDR);
  assign prdata = (paddr == bc7p_pkg::REG_FORMAT_ADDR) ? {30'b0, block_format} : '0;
  assign fmt0   = (block_format == bc7p_pkg::FMT_MODE1);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= bc7p_pkg::FMT_MODE1;
    end else if (cfg_wr) begin
      block_format <= pwdata[1:0];
    end
  end

  // request acceptance and small stores
  logic       acc;
  logic [7:0] ep_store [16];
  logic [7:0] luma_range [4];
  logic [5:0] shape_number;

  assign req_stall = (state != S_IDLE) || done_pend;
  assign acc       = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_number <= '0;
    end else if (acc && req_data.mode == bc7p_pkg::MODE_HEADER) begin
      shape_number <= req_data.partition;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && req_data.mode == bc7p_pkg::MODE_HEADER) begin
      luma_range[0] <= req_data.val_a;
      luma_range[1] <= req_data.val_b;
      luma_range[2] <= req_data.val_c;
      luma_range[3] <= req_data.val_d;
    end
    if (acc && req_data.mode == bc7p_pkg::MODE_ENDPOINT && !req_data.slot[3]
        && !req_data.slot[2]) begin
      ep_store[{req_data.slot[1:0], 2'd0}] <= req_data.val_a;
      ep_store[{req_data.slot[1:0], 2'd1}] <= req_data.val_b;
      ep_store[{req_data.slot[1:0], 2'd2}] <= req_data.val_c;
      ep_store[{req_data.slot[1:0], 2'd3}] <= req_data.val_d;
    end
  end

  // per-subset derived values
  logic [15:0] mask;
  logic [3:0]  ank;
  logic [8:0]  sum [2];
  logic [7:0]  mid [2];
  logic signed [9:0] dvs [2];

  assign mask = bc7p_pkg::SHAPE_MASK[shape_number];
  assign ank  = bc7p_pkg::SECOND_ANCHOR[shape_number];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      sum[s] = {1'b0, luma_range[2*s]} + {1'b0, luma_range[2*s+1]};
      mid[s] = sum[s][8:1];
      dvs[s] = $signed({2'b0, luma_range[2*s+1]}) - $signed({2'b0, mid[s]}) + 10'sd1;
    end
  end

  // luma RAM
  logic        pix_last;
  logic [3:0]  raddr;
  logic [15:0] rdata;

  assign pix_last = acc && req_data.mode == bc7p_pkg::MODE_PIXEL && req_data.slot == 4'd15;

  bc7p_luma_mem u_mem (
    .clk   (clk),
    .we    (acc && req_data.mode == bc7p_pkg::MODE_PIXEL),
    .waddr (req_data.slot),
    .wdata ({req_data.val_b, req_data.val_a}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // scale divider, shared by both subsets
  bc7p_pkg::div_ctrl_t dctl;
  logic signed [16:0]  div_q;
  logic signed [16:0]  scale [2];

  assign dctl.start = (state == S_ANC2) || (state == S_DIV0 && dctl.done);

  bc7p_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (dctl.start),
    .divisor ((state == S_ANC2) ? dvs[0] : dvs[1]),
    .done    (dctl.done),
    .scale   (div_q)
  );

  // index pipeline
  logic [4:0] rc;
  logic       va, vb, vc;
  logic [3:0] pa, pb, pc;
  logic       swap [2];
  logic signed [9:0]  diff_b;
  logic signed [16:0] scale_b;
  logic               anc_b, anc_c;
  logic signed [27:0] prod_c;
  logic [45:0] idxacc;
  logic [5:0]  ipos;

  // stage A: select subset, mirror, subtract mid
  logic       sub_a;
  logic [7:0] raw_a, v_a;
  logic       mir_a;
  always_comb begin
    sub_a = (pa == 4'd0) ? 1'b0 : mask[pa];
    raw_a = sub_a ? rdata[15:8] : rdata[7:0];
    mir_a = swap[sub_a] && (mask[pa] == sub_a);
    v_a   = mir_a ? 8'(sum[sub_a] - {1'b0, raw_a}) : raw_a;
  end

  // stage C: slot, table lookup, anchor clamp
  logic [3:0] slot_c;
  logic [2:0] idx_c;
  logic [5:0] nb_c;
  always_comb begin
    if (prod_c[27]) begin
      slot_c = 4'd0;
    end else if (prod_c[26:17] != '0) begin
      slot_c = 4'd15;
    end else begin
      slot_c = prod_c[16:13];
    end
    idx_c = fmt0 ? bc7p_pkg::IDX3[slot_c] : bc7p_pkg::IDX2[slot_c];
    nb_c  = fmt0 ? 6'd3 : 6'd2;
    if (anc_c) begin
      nb_c = nb_c - 6'd1;
      if (fmt0 && idx_c > 3'd3) begin
        idx_c = 3'd3;
      end else if (!fmt0 && idx_c > 3'd1) begin
        idx_c = 3'd1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    raddr      = rc[3:0];
    unique case (state)
      S_IDLE: if (pix_last) state_next = S_ANC0;
      S_ANC0: begin
        raddr      = 4'd0;
        state_next = S_ANC1;
      end
      S_ANC1: begin
        raddr      = ank;
        state_next = S_ANC2;
      end
      S_ANC2: state_next = S_DIV0;
      S_DIV0: if (dctl.done) state_next = S_DIV1;
      S_DIV1: if (dctl.done) state_next = S_PIX;
      S_PIX:  if (vc && pc == 4'd15) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      rc        <= '0;
      done_pend <= 1'b0;
    end else begin
      state <= state_next;
      vb    <= va;
      vc    <= vb;
      va    <= (state == S_PIX) && !rc[4];
      if (state == S_ANC0) begin
        rc <= '0;
      end else if (state == S_PIX && !rc[4]) begin
        rc <= rc + 5'd1;
      end
      if (state == S_PIX && vc && pc == 4'd15) begin
        done_pend <= 1'b1;
      end else if (done_pend && !res_valid) begin
        done_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ANC1) swap[0] <= (rdata[7:0] >= mid[0]);
    if (state == S_ANC2) swap[1] <= (rdata[15:8] >= mid[1]);
    if (state == S_DIV0 && dctl.done) scale[0] <= div_q;
    if (state == S_DIV1 && dctl.done) scale[1] <= div_q;
    pa      <= rc[3:0];
    pb      <= pa;
    pc      <= pb;
    diff_b  <= $signed({2'b0, v_a}) - $signed({2'b0, mid[sub_a]});
    scale_b <= scale[sub_a];
    anc_b   <= (pa == 4'd0) || (sub_a && pa == ank);
    anc_c   <= anc_b;
    prod_c  <= 28'(diff_b) * 28'(scale_b) + 28'sd65536;
    if (state == S_ANC0) begin
      idxacc <= '0;
      ipos   <= '0;
    end else if (vc) begin
      idxacc <= idxacc | 46'({43'b0, idx_c} << ipos);
      ipos   <= ipos + nb_c;
    end
  end

  // header fields: mode bits, partition, truncated endpoints, p-bits
  logic [7:0]   epv [4][4]; // endpoint (2*subset+end), channel
  logic [7:0]   pm  [4];
  logic [127:0] hdr;
  logic [127:0] blk;

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      for (int c = 0; c < 4; c++) begin
        epv[e][c] = ep_store[c*4 + (e & 2) + ((e & 1) ^ int'(swap[e/2]))];
      end
      pm[e] = (epv[e][0] & epv[e][1]) | (epv[e][1] & epv[e][2]) | (epv[e][0] & epv[e][2]);
    end
    hdr = '0;
    case (block_format)
      bc7p_pkg::FMT_MODE1: begin
        hdr[1]   = 1'b1;
        hdr[7:2] = shape_number;
        for (int c = 0; c < 3; c++) begin
          for (int e = 0; e < 4; e++) begin
            hdr[8 + (c*4+e)*6 +: 6] = epv[e][c][7:2];
          end
        end
        hdr[80] = pm[0][1] & pm[2][1];
        hdr[81] = pm[1][1] & pm[3][1];
      end
      bc7p_pkg::FMT_MODE3: begin
        hdr[3]   = 1'b1;
        hdr[9:4] = shape_number;
        for (int c = 0; c < 3; c++) begin
          for (int e = 0; e < 4; e++) begin
            hdr[10 + (c*4+e)*7 +: 7] = epv[e][c][7:1];
          end
        end
        for (int e = 0; e < 4; e++) hdr[94+e] = pm[e][0];
      end
      default: begin
        hdr[7]    = 1'b1;
        hdr[13:8] = shape_number;
        for (int c = 0; c < 4; c++) begin
          for (int e = 0; e < 4; e++) begin
            hdr[14 + (c*4+e)*5 +: 5] = epv[e][c][7:3];
          end
        end
        for (int e = 0; e < 4; e++) hdr[94+e] = pm[e][2];
      end
    endcase
    blk = hdr | (fmt0 ? {idxacc, 82'b0} : {idxacc[29:0], 98'b0});
  end

  // result buffer: whole block, two words out
  logic [127:0] obuf;
  logic         half;
  logic         load;

  assign load = done_pend && !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
      half      <= 1'b0;
    end else if (res_valid && !res_stall) begin
      if (half) res_valid <= 1'b0;
      half <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) obuf <= blk;
  end

  assign res_data.block_word = half ? obuf[127:64] : obuf[63:0];
  assign res_data.upper_half = half;
  assign res_data.last       = half;

  // checks
  `BC7P_ASSERT_NEXT(a_load_first_half, clk, rst, load, res_valid && !half)
  `BC7P_ASSERT_IMP(a_div_done_in_div, clk, rst, dctl.done, state == S_DIV0 || state == S_DIV1)
  `BC7P_ASSERT_IMP(a_pipe_in_pix, clk, rst, vc, state == S_PIX)
  `BC7P_ASSERT_IMP(a_no_pack_while_full, clk, rst, pix_last, !done_pend)

endmodule

FILE: rtl/core/bc7p_luma_mem.sv
// ----------------------------------------------------------------------------
// BC7 packer luma memory
// 16 x 16 synchronous RAM, subset 1 luma in the upper byte.
// ----------------------------------------------------------------------------
module bc7p_luma_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [15:0] wdata,
  input  logic [3:0]  raddr,
  output logic [15:0] rdata
);

  logic [15:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bc7p_div.sv
// ----------------------------------------------------------------------------
// BC7 packer scale divider
// Restoring divider, 32768 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bc7p_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [9:0]  divisor,
  output logic               done,
  output logic signed [16:0] scale
);

  logic        busy;
  logic [3:0]  cnt;
  logic [15:0] dvd;
  logic [7:0]  rem;
  logic [15:0] quo;
  logic [7:0]  mag;
  logic        neg;
  logic        zero;
  logic [9:0]  abs_d;
  logic [8:0]  trial;

  assign abs_d = divisor[9] ? 10'(-divisor) : divisor;
  assign trial = {rem, dvd[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 4'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      dvd  <= 16'h8000;
      rem  <= '0;
      quo  <= '0;
      mag  <= abs_d[7:0];
      neg  <= divisor[9];
      zero <= (divisor == '0);
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      dvd <= {dvd[14:0], 1'b0};
      if (trial >= {1'b0, mag}) begin
        rem <= 8'(trial - {1'b0, mag});
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= trial[7:0];
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (zero) begin
      scale = 17'sd32768;
    end else if (neg) begin
      scale = -$signed({1'b0, quo});
    end else begin
      scale = $signed({1'b0, quo});
    end
  end

endmodule
